// ===== design/zns_pkg.sv =====
`timescale 1ns / 1ps

package zns_pkg;

  localparam int LAYER_BITS    = 7;
  localparam int LAYERS        = 1 << LAYER_BITS;
  localparam int MAG_BITS      = 64 - LAYER_BITS - 1;
  localparam int OUT_FRAC_BITS = 24;
  localparam int UNIFORM_BITS  = 32;

  localparam logic [63:0] ONE_Q32    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LN2_Q32    = 64'h0000_0000_B172_17F8;
  localparam logic [63:0] SQRT_LIMIT = (64'd1 << 38) - 64'd1;
  localparam logic [63:0] SAT_MAG    = 64'h0000_0000_7FFF_FFFF;

  localparam logic [LAYER_BITS-1:0] LAST_LAYER = LAYER_BITS'(LAYERS - 1);

  // Number of terms in the exponential series and last odd term of the log series.
  localparam logic [4:0] EXP_TERMS = 5'd16;
  localparam logic [4:0] LOG_LAST  = 5'd25;

  typedef struct packed {
    logic [LAYERS-1:0][MAG_BITS-1:0] thr;
    logic [LAYERS-1:0][31:0]         edg;
    logic [LAYERS-1:0][32:0]         hgt;
  } zns_tab_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LMUL,  ST_LMULW,
    ST_GSQ,   ST_GSQW,
    ST_EDIV,  ST_EDIVW,
    ST_EMUL,  ST_EMULW,
    ST_EKDIV, ST_EKDIVW,
    ST_EFIN,
    ST_WCMP,  ST_WMULW,
    ST_TSTART,
    ST_LNORM,
    ST_LZDIV, ST_LZDIVW,
    ST_LZ2,   ST_LZ2W,
    ST_LKDIV, ST_LKDIVW,
    ST_LPMUL, ST_LPMULW,
    ST_LNMUL, ST_LNMULW,
    ST_TSQ,   ST_TSQW,
    ST_TMUL,  ST_TMULW,
    ST_EMIT
  } zns_state_e;

  // Floored Q32 product, wrapping at 64 bits.
  function automatic logic [63:0] f_mulq(logic [63:0] a, logic [63:0] b);
    logic [63:0] ah, al, bh, bl;
    ah = {32'b0, a[63:32]};
    al = {32'b0, a[31:0]};
    bh = {32'b0, b[63:32]};
    bl = {32'b0, b[31:0]};
    return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
  endfunction

  // floor(a * 2^s / b) by long division, all ones for a zero divisor.
  function automatic logic [63:0] f_divs(logic [63:0] a, logic [63:0] b, int s);
    logic [64:0] r;
    logic [63:0] q;
    logic        bin;
    r = '0;
    q = '0;
    if (b == 64'd0) begin
      return '1;
    end
    for (int j = 0; j < 64 + s; j++) begin
      bin = (j < 64) ? a[63-j] : 1'b0;
      r = {r[63:0], bin};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q = {q[62:0], 1'b1};
      end else begin
        q = {q[62:0], 1'b0};
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] f_exp_m(logic [63:0] y);
    logic [63:0] n, r, term, pos, neg;
    n    = f_divs(y, LN2_Q32, 0);
    r    = y - n * LN2_Q32;
    term = ONE_Q32;
    pos  = ONE_Q32;
    neg  = '0;
    for (int k = 1; k <= 16; k++) begin
      term = f_divs(f_mulq(term, r), 64'(k), 0);
      if ((k & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic logic [63:0] f_exp_neg(logic [63:0] y);
    logic [63:0] n, m;
    n = f_divs(y, LN2_Q32, 0);
    m = f_exp_m(y);
    return (n >= 64'd40) ? 64'd0 : (m >> n[5:0]);
  endfunction

  function automatic logic [63:0] f_gauss(logic [63:0] x);
    return f_exp_neg(f_mulq(x, x) >> 1);
  endfunction

  function automatic logic [63:0] f_neg_log(logic [63:0] tin);
    logic [63:0] t, n, z, z2, p, sum;
    t   = tin;
    n   = '0;
    sum = '0;
    if (t == 64'd0) begin
      t = 64'd1;
    end
    if (t >= ONE_Q32) begin
      return 64'd0;
    end
    for (int j = 0; j < 64; j++) begin
      if (t < (ONE_Q32 >> 1)) begin
        t = t << 1;
        n = n + 64'd1;
      end
    end
    z  = f_divs(ONE_Q32 - t, ONE_Q32 + t, 32);
    z2 = f_mulq(z, z);
    p  = z;
    for (int k = 1; k <= 25; k += 2) begin
      sum = sum + f_divs(p, 64'(k), 0);
      p   = f_mulq(p, z2);
    end
    return n * LN2_Q32 + (sum << 1);
  endfunction

  function automatic logic [63:0] f_sqrt(logic [63:0] sin);
    logic [63:0] v, res, bt;
    v   = (sin > SQRT_LIMIT) ? SQRT_LIMIT : sin;
    v   = v << 24;
    res = '0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res << 4;
  endfunction

  localparam logic [63:0] R_Q32  = f_divs(64'd3442619855899, 64'd1000000000000, 32);
  localparam logic [63:0] V_Q32  = f_divs(64'd9912563035, 64'd1000000000000, 32);
  localparam logic [63:0] RR_Q32 = f_mulq(R_Q32, R_Q32);

  function automatic zns_tab_t f_build();
    zns_tab_t    tb;
    logic [63:0] x, n, e, t, tmp;
    e   = f_exp_m(RR_Q32 >> 1);
    n   = f_divs(RR_Q32 >> 1, LN2_Q32, 0);
    tmp = f_divs(V_Q32, e, 32 + int'(n[5:0])) >> 4;
    tb.edg[LAYERS-1] = tmp[31:0];
    tmp = R_Q32 >> 4;
    tb.edg[LAYERS-2] = tmp[31:0];
    tmp = f_gauss(R_Q32);
    tb.hgt[LAYERS-1] = tmp[32:0];
    x = R_Q32;
    for (int i = LAYERS - 2; i >= 1; i--) begin
      t   = f_gauss(x) + f_divs(V_Q32, x, 32);
      x   = f_sqrt(f_neg_log(t) << 1);
      tmp = x >> 4;
      tb.edg[i-1] = tmp[31:0];
      tmp = f_gauss(x);
      tb.hgt[i] = tmp[32:0];
    end
    tb.hgt[0] = ONE_Q32[32:0];
    tb.thr[0] = '0;
    for (int i = 1; i < LAYERS; i++) begin
      tmp = f_divs({32'b0, tb.edg[i-1]}, {32'b0, tb.edg[i]}, MAG_BITS);
      tb.thr[i] = tmp[MAG_BITS-1:0];
    end
    return tb;
  endfunction

  localparam zns_tab_t ZNS_TAB = f_build();

  // A uniform word as a Q32 fraction.
  function automatic logic [63:0] f_unif(logic [31:0] w);
    logic [63:0] v;
    v = {32'b0, w} & ((64'd1 << UNIFORM_BITS) - 64'd1);
    return v << (32 - UNIFORM_BITS);
  endfunction

endpackage

// ===== design/zns_mulq.sv =====
`timescale 1ns / 1ps

module zns_mulq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  import zns_pkg::*;

  logic [63:0] a_q, b_q, prod_q, acc_q, term;
  logic [31:0] x_sel, y_sel;
  logic [63:0] prod_d;
  logic [2:0]  step_q;
  logic        busy_q, done_q;

  // One 32x32 partial product per cycle, registered and added in the next cycle.
  always_comb begin
    x_sel  = step_q[0] ? a_q[63:32] : a_q[31:0];
    y_sel  = step_q[1] ? b_q[63:32] : b_q[31:0];
    prod_d = {32'b0, x_sel} * {32'b0, y_sel};
    unique case (step_q)
      3'd1:    term = prod_q >> 32;
      3'd2:    term = prod_q;
      3'd3:    term = prod_q;
      3'd4:    term = prod_q << 32;
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_d;
      acc_q  <= acc_q + term;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== design/zns_divq.sv =====
`timescale 1ns / 1ps

module zns_divq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        long_i,
  output logic        done_o,
  output logic [63:0] q_o
);
  import zns_pkg::*;

  logic [95:0] d_q;
  logic [63:0] b_q, q_q, r_q;
  logic [64:0] r2, rs;
  logic        ge;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q, bz_q;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    r2 = {r_q, d_q[95]};
    rs = r2 - {1'b0, b_q};
    ge = r2 >= {1'b0, b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= long_i ? 7'd96 : 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q  <= {a_i, 32'b0};
      b_q  <= b_i;
      bz_q <= (b_i == 64'd0);
      q_q  <= '0;
      r_q  <= '0;
    end else if (busy_q) begin
      d_q <= {d_q[94:0], 1'b0};
      q_q <= {q_q[62:0], ge};
      r_q <= ge ? rs[63:0] : r2[63:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = bz_q ? '1 : q_q;

endmodule

// ===== design/zns_isqrt.sv =====
`timescale 1ns / 1ps

module zns_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] v_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  import zns_pkg::*;

  logic [63:0] v_q, res_q, bit_q, trial;
  logic        busy_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Two radicand bits per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q[31:0];

endmodule

// ===== design/ziggurat_normal_sampler.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | word_a_i, word_b_i, wedge_uniform_i,
//         |           |                         | tail_uniform_a_i, tail_uniform_b_i
// out     | output    | out_valid_o / out_stall_i | sample_o (Q7.24), from_tail_o
//
// One beat is taken at a time; in_stall_o is high from acceptance until the attempt ends.
// A fast layer accept needs a single multiply; a wedge test runs the exponential series
// and a tail attempt the log series (one more normalising shift for each leading zero of
// the log argument), both on the bit-serial divider (64 or 96 quotient bits per division).
// Reset clears the sequencer, the tail mode flag, the held sign and the output valid flag.
// A finished sample waits in the output register while the next beat is taken in.
module ziggurat_normal_sampler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        word_a_i,
  input  logic [31:0]        word_b_i,
  input  logic [31:0]        wedge_uniform_i,
  input  logic [31:0]        tail_uniform_a_i,
  input  logic [31:0]        tail_uniform_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sample_o,
  output logic               from_tail_o
);
  import zns_pkg::*;

  zns_state_e state_q, state_d;

  // Control state.
  logic tail_pending_q, held_sign_q, out_valid_q;

  // Working registers of the sequencer.
  logic [LAYER_BITS-1:0] i_q;
  logic [MAG_BITS-1:0]   u_q;
  logic                  pos_q, tail_q, nbig_q;
  logic [31:0]           uw_q, ua_q, ub_q, rr_q, t_q;
  logic [63:0]           x_q, s_q, term_q, accp_q, accn_q, g_q;
  logic [63:0]           z_q, z2_q, p_q, sum_q;
  logic [4:0]            k_q;
  logic [5:0]            nsh_q, ln_n_q;
  logic signed [31:0]    sample_q;
  logic                  from_tail_q;

  // Shared unit ports.
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic        div_start, div_long, div_done;
  logic [63:0] div_a, div_b, div_q;
  logic        sqrt_start, sqrt_done;
  logic [63:0] sqrt_v, s_sat;
  logic [31:0] sqrt_res;

  // Table lookups and derived values.
  logic [LAYER_BITS-1:0] i_nx;
  logic [63:0]           h_cur, h_nx, h_diff, emag;
  logic [30:0]           mag31;
  logic                  in_acc, out_free, fast_ok;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign i_nx     = i_q + LAYER_BITS'(1);
  assign h_cur    = {31'b0, ZNS_TAB.hgt[i_q]};
  assign h_nx     = {31'b0, ZNS_TAB.hgt[i_nx]};
  assign h_diff   = (h_cur > h_nx) ? h_cur - h_nx : 64'd0;
  assign fast_ok  = u_q < ZNS_TAB.thr[i_q];
  assign s_sat    = (s_q > SQRT_LIMIT) ? SQRT_LIMIT : s_q;
  assign sqrt_v   = s_sat << 24;

  // Output formatting: truncate to the output fraction width, saturate, then apply the sign.
  assign emag  = x_q >> (32 - OUT_FRAC_BITS);
  assign mag31 = (emag > SAT_MAG) ? SAT_MAG[30:0] : emag[30:0];

  zns_mulq u_mulq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  zns_divq u_divq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .long_i  (div_long),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  zns_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (sqrt_v),
    .done_o  (sqrt_done),
    .res_o   (sqrt_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The sequencer: next state, unit launches and operand selection.
  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    div_long   = 1'b0;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tail_pending_q ? ST_TSTART : ST_LMUL;
        end
      end
      ST_LMUL: begin
        mul_start = 1'b1;
        mul_a     = {8'b0, u_q};
        mul_b     = {32'b0, ZNS_TAB.edg[i_q]};
        state_d   = ST_LMULW;
      end
      ST_LMULW: begin
        if (mul_done) begin
          if (fast_ok) begin
            state_d = ST_EMIT;
          end else if (i_q != LAST_LAYER) begin
            state_d = ST_GSQ;
          end else begin
            state_d = ST_TSTART;
          end
        end
      end
      ST_GSQ: begin
        mul_start = 1'b1;
        mul_a     = x_q;
        mul_b     = x_q;
        state_d   = ST_GSQW;
      end
      ST_GSQW: begin
        if (mul_done) begin
          state_d = ST_EDIV;
        end
      end
      ST_EDIV: begin
        // Range reduction by ln 2, one compare and subtract per cycle; the argument is below eight.
        if (s_q < LN2_Q32) begin
          state_d = ST_EDIVW;
        end
      end
      ST_EDIVW: begin
        state_d = ST_EMUL;
      end
      ST_EMUL: begin
        mul_start = 1'b1;
        mul_a     = term_q;
        mul_b     = {32'b0, rr_q};
        state_d   = ST_EMULW;
      end
      ST_EMULW: begin
        if (mul_done) begin
          state_d = ST_EKDIV;
        end
      end
      ST_EKDIV: begin
        div_start = 1'b1;
        div_a     = term_q;
        div_b     = {59'b0, k_q};
        state_d   = ST_EKDIVW;
      end
      ST_EKDIVW: begin
        if (div_done) begin
          state_d = (k_q == EXP_TERMS) ? ST_EFIN : ST_EMUL;
        end
      end
      ST_EFIN: begin
        state_d = ST_WCMP;
      end
      ST_WCMP: begin
        if (g_q < h_nx) begin
          state_d = ST_IDLE;
        end else begin
          mul_start = 1'b1;
          mul_a     = f_unif(uw_q);
          mul_b     = h_diff;
          state_d   = ST_WMULW;
        end
      end
      ST_WMULW: begin
        if (mul_done) begin
          state_d = (mul_p <= g_q - h_nx) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_TSTART: begin
        state_d = (f_unif(ua_q) == 64'd0) ? ST_TSQ : ST_LNORM;
      end
      ST_LNORM: begin
        if (t_q[31]) begin
          state_d = ST_LZDIV;
        end
      end
      ST_LZDIV: begin
        div_start = 1'b1;
        div_a     = ONE_Q32 - {32'b0, t_q};
        div_b     = ONE_Q32 + {32'b0, t_q};
        div_long  = 1'b1;
        state_d   = ST_LZDIVW;
      end
      ST_LZDIVW: begin
        if (div_done) begin
          state_d = ST_LZ2;
        end
      end
      ST_LZ2: begin
        mul_start = 1'b1;
        mul_a     = z_q;
        mul_b     = z_q;
        state_d   = ST_LZ2W;
      end
      ST_LZ2W: begin
        if (mul_done) begin
          state_d = ST_LKDIV;
        end
      end
      ST_LKDIV: begin
        div_start = 1'b1;
        div_a     = p_q;
        div_b     = {59'b0, k_q};
        state_d   = ST_LKDIVW;
      end
      ST_LKDIVW: begin
        if (div_done) begin
          state_d = (k_q == LOG_LAST) ? ST_LNMUL : ST_LPMUL;
        end
      end
      ST_LPMUL: begin
        mul_start = 1'b1;
        mul_a     = p_q;
        mul_b     = z2_q;
        state_d   = ST_LPMULW;
      end
      ST_LPMULW: begin
        if (mul_done) begin
          state_d = ST_LKDIV;
        end
      end
      ST_LNMUL: begin
        mul_start = 1'b1;
        mul_a     = {26'b0, ln_n_q, 32'b0};
        mul_b     = LN2_Q32;
        state_d   = ST_LNMULW;
      end
      ST_LNMULW: begin
        if (mul_done) begin
          state_d = ST_TSQ;
        end
      end
      ST_TSQ: begin
        sqrt_start = 1'b1;
        state_d    = ST_TSQW;
      end
      ST_TSQW: begin
        if (sqrt_done) begin
          state_d = ST_TMUL;
        end
      end
      ST_TMUL: begin
        mul_start = 1'b1;
        mul_a     = x_q;
        mul_b     = f_unif(ub_q);
        state_d   = ST_TMULW;
      end
      ST_TMULW: begin
        if (mul_done) begin
          state_d = (mul_p <= R_Q32) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Tail mode, held sign and the output register are the only state that outlives an attempt.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_pending_q <= 1'b0;
      held_sign_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (state_q == ST_TMULW && mul_done) begin
        if (mul_p <= R_Q32) begin
          tail_pending_q <= 1'b0;
        end else begin
          tail_pending_q <= 1'b1;
          held_sign_q    <= pos_q;
        end
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the attempt in flight.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          i_q   <= word_a_i[LAYER_BITS-1:0];
          u_q   <= {word_a_i[31:LAYER_BITS+1], word_b_i};
          pos_q <= tail_pending_q ? held_sign_q : word_a_i[LAYER_BITS];
          uw_q  <= wedge_uniform_i;
          ua_q  <= tail_uniform_a_i;
          ub_q  <= tail_uniform_b_i;
        end
      end
      ST_LMULW: begin
        if (mul_done) begin
          x_q    <= mul_p >> 20;
          tail_q <= 1'b0;
        end
      end
      ST_GSQW: begin
        if (mul_done) begin
          s_q   <= mul_p >> 1;
          nsh_q <= '0;
        end
      end
      ST_EDIV: begin
        if (s_q >= LN2_Q32) begin
          s_q   <= s_q - LN2_Q32;
          nsh_q <= nsh_q + 6'd1;
        end
      end
      ST_EDIVW: begin
        nbig_q <= nsh_q >= 6'd40;
        rr_q   <= s_q[31:0];
        term_q <= ONE_Q32;
        accp_q <= ONE_Q32;
        accn_q <= '0;
        k_q    <= 5'd1;
      end
      ST_EMULW: begin
        if (mul_done) begin
          term_q <= mul_p;
        end
      end
      ST_EKDIVW: begin
        if (div_done) begin
          term_q <= div_q;
          if (k_q[0]) begin
            accn_q <= accn_q + div_q;
          end else begin
            accp_q <= accp_q + div_q;
          end
          k_q <= k_q + 5'd1;
        end
      end
      ST_EFIN: begin
        if (nbig_q || accp_q <= accn_q) begin
          g_q <= '0;
        end else begin
          g_q <= (accp_q - accn_q) >> nsh_q;
        end
      end
      ST_TSTART: begin
        s_q    <= RR_Q32;
        t_q    <= 32'(ONE_Q32 - f_unif(ua_q));
        ln_n_q <= '0;
      end
      ST_LNORM: begin
        if (!t_q[31]) begin
          t_q    <= {t_q[30:0], 1'b0};
          ln_n_q <= ln_n_q + 6'd1;
        end
      end
      ST_LZDIVW: begin
        if (div_done) begin
          z_q <= div_q;
        end
      end
      ST_LZ2W: begin
        if (mul_done) begin
          z2_q  <= mul_p;
          p_q   <= z_q;
          sum_q <= '0;
          k_q   <= 5'd1;
        end
      end
      ST_LKDIVW: begin
        if (div_done) begin
          sum_q <= sum_q + div_q;
        end
      end
      ST_LPMULW: begin
        if (mul_done) begin
          p_q <= mul_p;
          k_q <= k_q + 5'd2;
        end
      end
      ST_LNMULW: begin
        if (mul_done) begin
          s_q <= RR_Q32 + ((mul_p + (sum_q << 1)) << 1);
        end
      end
      ST_TSQW: begin
        if (sqrt_done) begin
          x_q    <= {28'b0, sqrt_res, 4'b0};
          tail_q <= 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          sample_q    <= pos_q ? $signed({1'b0, mag31}) : -$signed({1'b0, mag31});
          from_tail_q <= tail_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign from_tail_o = from_tail_q;

endmodule
